// ----- rtl/inverse_normal_sample_top_macros.svh -----
// Assertion helpers used by inverse_normal_sample_top.
`ifndef INVERSE_NORMAL_SAMPLE_TOP_MACROS_SVH
`define INVERSE_NORMAL_SAMPLE_TOP_MACROS_SVH

// Same-cycle implication on clk, off while rst is high.
`define INS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on clk, off while rst is high.
`define INS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ins_pkg.sv -----
package ins_pkg;

  localparam int UNIFORM_BITS_DEF = 32;
  localparam int FB     = 28;
  localparam int EXP_W  = 6;
  localparam int X_W    = FB + 1;
  localparam int L2_W   = EXP_W + FB;
  localparam int K2_W   = 29;
  localparam int TSQ_W  = L2_W + 1;
  localparam int N_W    = 64;
  localparam int T_W    = 32;
  localparam int REM_W  = 34;
  localparam int ACC_W  = 37;
  localparam int QUO_W  = 32;
  localparam int PB_W   = 4;
  localparam int ZM_W   = T_W + 1;
  localparam int MAG_W  = 37;

  localparam logic [K2_W-1:0] TWO_LN2 = 29'd372130559;

  typedef logic [ACC_W-1:0] coef_t;

  localparam logic [63:0] P0_64 = (64'd322232431088 * 64'd65536 + 64'd122070312) / 64'd244140625;
  localparam logic [63:0] P1_64 = (64'd1000000000000 * 64'd65536 + 64'd122070312) / 64'd244140625;
  localparam logic [63:0] P2_64 = (64'd342242088547 * 64'd65536 + 64'd122070312) / 64'd244140625;
  localparam logic [63:0] P3_64 =
    (64'd204231210245 * 64'd32768 + 64'd610351562) / 64'd1220703125;
  localparam logic [63:0] P4_64 =
    (64'd453642210148 * 64'd4096 + 64'd76293945312) / 64'd152587890625;
  localparam logic [63:0] Q0_64 = (64'd99348462606 * 64'd65536 + 64'd122070312) / 64'd244140625;
  localparam logic [63:0] Q1_64 = (64'd588581570495 * 64'd65536 + 64'd122070312) / 64'd244140625;
  localparam logic [63:0] Q2_64 = (64'd531103462366 * 64'd65536 + 64'd122070312) / 64'd244140625;
  localparam logic [63:0] Q3_64 = (64'd103537752850 * 64'd65536 + 64'd122070312) / 64'd244140625;
  localparam logic [63:0] Q4_64 = (64'd3856070063 * 64'd65536 + 64'd122070312) / 64'd244140625;

  localparam coef_t PCO [5] = '{coef_t'(P0_64), coef_t'(P1_64), coef_t'(P2_64),
                                coef_t'(P3_64), coef_t'(P4_64)};
  localparam coef_t QCO [5] = '{coef_t'(Q0_64), coef_t'(Q1_64), coef_t'(Q2_64),
                                coef_t'(Q3_64), coef_t'(Q4_64)};

  typedef struct packed {
    logic               upper;
    logic signed [31:0] mean;
    logic [30:0]        sd;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [EXP_W-1:0] e;
    logic [X_W-1:0]   x;
    logic [FB-1:0]    frac;
  } log_t;

  typedef struct packed {
    side_t            side;
    logic [N_W-1:0]   n;
    logic [REM_W-1:0] rem;
    logic [T_W-1:0]   root;
  } root_t;

  typedef struct packed {
    side_t            side;
    logic [T_W-1:0]   t;
    logic [ACC_W-1:0] p;
    logic [ACC_W-1:0] q;
  } poly_t;

  typedef struct packed {
    side_t            side;
    logic [T_W-1:0]   t;
    logic [ACC_W-1:0] q;
    logic [QUO_W-1:0] bits;
    logic [ACC_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

// ----- rtl/ins_log_cell.sv -----
module ins_log_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ins_pkg::log_t in_data,
  output logic          out_valid,
  output ins_pkg::log_t out_data
);
  import ins_pkg::*;

  logic [2*X_W-1:0] sq;
  logic [X_W:0]     y;
  log_t             data_next;

  always_comb begin
    sq        = in_data.x * in_data.x;
    y         = sq[2*X_W-1:FB];
    data_next = in_data;
    if (y[X_W]) begin
      data_next.x         = y[X_W:1];
      data_next.frac[BIT] = 1'b1;
    end else begin
      data_next.x = y[X_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// ----- rtl/ins_sqrt_cell.sv -----
module ins_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ins_pkg::root_t in_data,
  output logic           out_valid,
  output ins_pkg::root_t out_data
);
  import ins_pkg::*;

  logic [REM_W+1:0] cat;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] dif;
  root_t            data_next;

  always_comb begin
    cat            = {in_data.rem, in_data.n[N_W-1:N_W-2]};
    trial          = {2'b00, in_data.root, 2'b01};
    dif            = cat - trial;
    data_next      = in_data;
    data_next.n    = {in_data.n[N_W-3:0], 2'b00};
    if (cat >= trial) begin
      data_next.rem  = dif[REM_W-1:0];
      data_next.root = {in_data.root[T_W-2:0], 1'b1};
    end else begin
      data_next.rem  = cat[REM_W-1:0];
      data_next.root = {in_data.root[T_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// ----- rtl/ins_horner_cell.sv -----
module ins_horner_cell #(
  parameter ins_pkg::coef_t CP = '0,
  parameter ins_pkg::coef_t CQ = '0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ins_pkg::poly_t in_data,
  output logic           out_valid,
  output ins_pkg::poly_t out_data
);
  import ins_pkg::*;

  logic [ACC_W+T_W-1:0] mp;
  logic [ACC_W+T_W-1:0] mq;
  poly_t                data_next;

  always_comb begin
    mp          = in_data.p * in_data.t;
    mq          = in_data.q * in_data.t;
    data_next   = in_data;
    data_next.p = ACC_W'(CP + mp[ACC_W+T_W-1:FB]);
    data_next.q = ACC_W'(CQ + mq[ACC_W+T_W-1:FB]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// ----- rtl/ins_div_cell.sv -----
module ins_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ins_pkg::div_t in_data,
  output logic          out_valid,
  output ins_pkg::div_t out_data
);
  import ins_pkg::*;

  logic [ACC_W:0] cat;
  logic [ACC_W:0] dsr;
  logic [ACC_W:0] dif;
  div_t           data_next;

  always_comb begin
    cat            = {in_data.rem, in_data.bits[QUO_W-1]};
    dsr            = {1'b0, in_data.q};
    dif            = cat - dsr;
    data_next      = in_data;
    data_next.bits = {in_data.bits[QUO_W-2:0], 1'b0};
    if (cat >= dsr) begin
      data_next.rem = dif[ACC_W-1:0];
      data_next.quo = {in_data.quo[QUO_W-2:0], 1'b1};
    end else begin
      data_next.rem = cat[ACC_W-1:0];
      data_next.quo = {in_data.quo[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// ----- rtl/inverse_normal_sample_top.sv -----
// done and the result (sample, saturated) are registered together; the result is valid while done is high.
// Throughput: one transaction per cycle; busy stays low, start may be high every cycle.
// Depth is set by the cell rows: 28 log cells, 32 square-root cells,
// 4 Horner cells and 32 divider cells, plus six single stages.
// Reset: synchronous, active high; flushes every stage so no done follows.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "inverse_normal_sample_top_macros.svh"

module inverse_normal_sample_top #(
  parameter int UNIFORM_BITS = ins_pkg::UNIFORM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        uniform,
  input  logic signed [31:0] mean,
  input  logic [30:0]        std_dev,
  output logic               done,
  output logic signed [31:0] sample,
  output logic               saturated
);
  import ins_pkg::*;

  localparam int UB  = UNIFORM_BITS;
  localparam int KW  = $clog2(UB);
  localparam int LAT = 102;
  localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;

  assign busy = 1'b0;

  logic [UB-1:0] u_ext;
  logic [UB-1:0] u_fix;
  logic          up_next;
  logic [UB-1:0] v_next;

  generate
    if (UB > 32) begin : g_wide
      assign u_ext = {{(UB-32){1'b0}}, uniform};
    end else if (UB == 32) begin : g_equal
      assign u_ext = uniform;
    end else begin : g_narrow
      assign u_ext = uniform[UB-1:0];
    end
  endgenerate

  always_comb begin
    u_fix   = (u_ext == '0) ? {{(UB-1){1'b0}}, 1'b1} : u_ext;
    up_next = u_fix[UB-1];
    v_next  = up_next ? (UB'(0) - u_fix) : u_fix;
  end

  logic          s1_vld;
  side_t         s1_side;
  logic [UB-1:0] s1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_side <= '{upper: up_next, mean: mean, sd: std_dev};
    s1_v    <= v_next;
  end

  logic [KW-1:0]    k;
  logic [UB+FB-1:0] wide;
  log_t             l0_next;

  always_comb begin
    k = '0;
    for (int i = 0; i < UB; i++) begin
      if (s1_v[i]) begin
        k = KW'(i);
      end
    end
    wide         = {s1_v, {FB{1'b0}}} >> k;
    l0_next.side = s1_side;
    l0_next.e    = EXP_W'(UB) - EXP_W'(k);
    l0_next.x    = wide[FB:0];
    l0_next.frac = '0;
  end

  logic lg_vld [FB+1];
  log_t lg     [FB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_vld[0] <= 1'b0;
    end else begin
      lg_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    lg[0] <= l0_next;
  end

  generate
    for (genvar i = 0; i < FB; i++) begin : g_log
      ins_log_cell #(.BIT(FB-1-i)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (lg_vld[i]),
        .in_data   (lg[i]),
        .out_valid (lg_vld[i+1]),
        .out_data  (lg[i+1])
      );
    end
  endgenerate

  logic [L2_W-1:0]      l2;
  logic [L2_W+K2_W-1:0] tprod;
  logic [TSQ_W-1:0]     tsq;
  root_t                r0_next;

  always_comb begin
    l2           = {lg[FB].e, {FB{1'b0}}} - {{EXP_W{1'b0}}, lg[FB].frac};
    tprod        = l2 * TWO_LN2;
    tsq          = tprod[L2_W+K2_W-1:FB];
    r0_next.side = lg[FB].side;
    r0_next.n    = {1'b0, tsq, {FB{1'b0}}};
    r0_next.rem  = '0;
    r0_next.root = '0;
  end

  logic  rt_vld [T_W+1];
  root_t rt     [T_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_vld[0] <= 1'b0;
    end else begin
      rt_vld[0] <= lg_vld[FB];
    end
  end

  always_ff @(posedge clk) begin
    rt[0] <= r0_next;
  end

  generate
    for (genvar i = 0; i < T_W; i++) begin : g_sqrt
      ins_sqrt_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (rt_vld[i]),
        .in_data   (rt[i]),
        .out_valid (rt_vld[i+1]),
        .out_data  (rt[i+1])
      );
    end
  endgenerate

  logic  hp_vld [5];
  poly_t hp     [5];

  always_comb begin
    hp_vld[0]    = rt_vld[T_W];
    hp[0].side   = rt[T_W].side;
    hp[0].t      = rt[T_W].root;
    hp[0].p      = PCO[4];
    hp[0].q      = QCO[4];
  end

  generate
    for (genvar i = 0; i < 4; i++) begin : g_horner
      ins_horner_cell #(.CP(PCO[3-i]), .CQ(QCO[3-i])) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (hp_vld[i]),
        .in_data   (hp[i]),
        .out_valid (hp_vld[i+1]),
        .out_data  (hp[i+1])
      );
    end
  endgenerate

  logic dv_vld [QUO_W+1];
  div_t dv     [QUO_W+1];

  always_comb begin
    dv_vld[0]   = hp_vld[4];
    dv[0].side  = hp[4].side;
    dv[0].t     = hp[4].t;
    dv[0].q     = hp[4].q;
    dv[0].bits  = {hp[4].p[PB_W-1:0], {(QUO_W-PB_W){1'b0}}};
    dv[0].rem   = {{PB_W{1'b0}}, hp[4].p[ACC_W-1:PB_W]};
    dv[0].quo   = '0;
  end

  generate
    for (genvar i = 0; i < QUO_W; i++) begin : g_div
      ins_div_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (dv_vld[i]),
        .in_data   (dv[i]),
        .out_valid (dv_vld[i+1]),
        .out_data  (dv[i+1])
      );
    end
  endgenerate

  logic signed [T_W+1:0] dz;
  logic signed [T_W+1:0] dz_dir;
  logic [ZM_W-1:0]       zm_next;

  always_comb begin
    dz      = $signed({2'b00, dv[QUO_W].quo}) - $signed({2'b00, dv[QUO_W].t});
    dz_dir  = dv[QUO_W].side.upper ? -dz : dz;
    zm_next = dz_dir[T_W+1] ? ZM_W'(-dz_dir) : ZM_W'(dz_dir);
  end

  logic               z_vld;
  logic               z_neg;
  logic [ZM_W-1:0]    z_mag;
  logic signed [31:0] z_mean;
  logic [30:0]        z_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_vld <= 1'b0;
    end else begin
      z_vld <= dv_vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    z_neg  <= dz_dir[T_W+1];
    z_mag  <= zm_next;
    z_mean <= dv[QUO_W].side.mean;
    z_sd   <= dv[QUO_W].side.sd;
  end

  logic [31+ZM_W-1:0] sprod;
  logic [31+ZM_W:0]   sround;

  always_comb begin
    sprod  = z_sd * z_mag;
    sround = {1'b0, sprod} + (65'd1 << (FB-1));
  end

  logic               m_vld;
  logic               m_neg;
  logic [MAG_W-1:0]   m_mag;
  logic signed [31:0] m_mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= z_vld;
    end
  end

  always_ff @(posedge clk) begin
    m_neg  <= z_neg;
    m_mag  <= sround[FB+MAG_W-1:FB];
    m_mean <= z_mean;
  end

  logic signed [MAG_W+1:0] total;
  logic signed [31:0]      sample_next;
  logic                    sat_next;

  always_comb begin
    if (m_neg) begin
      total = (MAG_W+2)'(m_mean) - $signed({2'b00, m_mag});
    end else begin
      total = (MAG_W+2)'(m_mean) + $signed({2'b00, m_mag});
    end
    sat_next = 1'b1;
    if (total > (MAG_W+2)'(S_MAX)) begin
      sample_next = S_MAX;
    end else if (total < (MAG_W+2)'(S_MIN)) begin
      sample_next = S_MIN;
    end else begin
      sample_next = total[31:0];
      sat_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    sample    <= sample_next;
    saturated <= sat_next;
  end

  `INS_ASSERT_IMPL(a_done_has_start, done, $past(start && !busy, LAT), "done without a transaction")
  `INS_ASSERT_NEXT(a_no_stray_done, !$past(start && !busy, LAT-1), !done, "stray done")
  `INS_ASSERT_IMPL(a_sat_clamps, done && saturated, sample == S_MAX || sample == S_MIN, "bad clamp")
  `INS_ASSERT_IMPL(a_zero_sd, done && $past(std_dev == 31'd0, LAT), sample == $past(mean, LAT) && !saturated, "zero std_dev must give mean")

endmodule

// ----- tb/sv/inverse_normal_sample_top_tb.sv -----
module inverse_normal_sample_top_tb;

  typedef struct {
    logic [31:0]        uniform;
    logic signed [31:0] mean;
    logic [30:0]        std_dev;
    bit                 drain;
  } gauss_req_t;

  typedef struct {
    logic signed [31:0] sample;
    logic               saturated;
  } gauss_res_t;

  localparam int QF = 28;
  localparam int UB = 32;
  localparam int LATENCY = 102;
  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        uniform = '0;
  logic signed [31:0] mean = '0;
  logic [30:0]        std_dev = '0;
  logic               done;
  logic signed [31:0] sample;
  logic               saturated;

  gauss_req_t pending_q[$];
  gauss_res_t expected_q[$];
  int         errors = 0;
  int         n_sent = 0;
  int         n_checked = 0;
  int         n_sat = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         gap_left = 0;

  logic [63:0] pco[5];
  logic [63:0] qco[5];

  inverse_normal_sample_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .uniform(uniform), .mean(mean), .std_dev(std_dev),
    .done(done), .sample(sample), .saturated(saturated)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] minus_log2(input logic [63:0] v);
    int          k;
    logic [63:0] x;
    logic [63:0] frac;
    k = 63;
    frac = 0;
    while (k > 0 && v[k] == 1'b0) k--;
    x = (k >= QF) ? (v >> (k - QF)) : (v << (QF - k));
    for (int i = 0; i < QF; i++) begin
      x = (x * x) >> QF;
      if (x >= (64'd2 << QF)) begin
        x = x >> 1;
        frac[QF-1-i] = 1'b1;
      end
    end
    return (64'(UB - k) << QF) - frac;
  endfunction

  function automatic logic [63:0] quartic(input logic [63:0] c[5], input logic [63:0] t);
    logic [63:0] acc;
    acc = c[4];
    for (int i = 3; i >= 0; i--) acc = c[i] + ((acc * t) >> QF);
    return acc;
  endfunction

  function automatic gauss_res_t expected_result(input gauss_req_t r);
    gauss_res_t  res;
    logic [63:0] u, v, t, ratio, zmag, mag;
    bit          upper;
    longint      diff, total;
    u = 64'(r.uniform);
    if (u == 0) u = 1;
    upper = (u >= (64'd1 << (UB - 1)));
    v = upper ? ((64'd1 << UB) - u) : u;
    t = root_floor(((minus_log2(v) * 64'd372130559) >> QF) << QF);
    ratio = (quartic(pco, t) << QF) / quartic(qco, t);
    diff = longint'(ratio) - longint'(t);
    if (upper) diff = -diff;
    zmag = (diff < 0) ? 64'(-diff) : 64'(diff);
    mag = (64'(r.std_dev) * zmag + (64'd1 << (QF - 1))) >> QF;
    total = longint'(r.mean) + ((diff < 0) ? -longint'(mag) : longint'(mag));
    res.saturated = 1'b0;
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
      res.saturated = 1'b1;
    end else if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
      res.saturated = 1'b1;
    end
    res.sample = total[31:0];
    return res;
  endfunction

  task automatic add_item(input logic [31:0] u, input logic [31:0] m, input logic [30:0] s,
                          input bit drain);
    gauss_req_t r;
    r.uniform = u;
    r.mean = m;
    r.std_dev = s;
    r.drain = drain;
    pending_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    gauss_req_t nxt;
    bit         go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(expected_result(pending_q.pop_front()));
        n_sent++;
      end
      go = 0;
      if (pending_q.size() > 0) begin
        nxt = pending_q[0];
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(nxt.drain && expected_q.size() > 0)) begin
          go = 1;
          burst_left--;
        end
      end
      if (go) begin
        start <= 1'b1;
        uniform <= nxt.uniform;
        mean <= nxt.mean;
        std_dev <= nxt.std_dev;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    gauss_res_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result sample=%h saturated=%b", $time, sample, saturated);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.saturated) n_sat++;
        if (sample !== e.sample) begin
          $display("%0t: sample expected %h actual %h", $time, e.sample, sample);
          errors++;
        end
        if (saturated !== e.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, e.saturated, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] u, m;
    logic [30:0] s;
    for (int i = 0; i < 5; i++) begin
      pco[i] = 0;
      qco[i] = 0;
    end
    pco[0] = (64'd322232431088 * 65536 + 64'd122070312) / 64'd244140625;
    pco[1] = (64'd1000000000000 * 65536 + 64'd122070312) / 64'd244140625;
    pco[2] = (64'd342242088547 * 65536 + 64'd122070312) / 64'd244140625;
    pco[3] = (64'd204231210245 * 32768 + 64'd610351562) / 64'd1220703125;
    pco[4] = (64'd453642210148 * 4096 + 64'd76293945312) / 64'd152587890625;
    qco[0] = (64'd99348462606 * 65536 + 64'd122070312) / 64'd244140625;
    qco[1] = (64'd588581570495 * 65536 + 64'd122070312) / 64'd244140625;
    qco[2] = (64'd531103462366 * 65536 + 64'd122070312) / 64'd244140625;
    qco[3] = (64'd103537752850 * 65536 + 64'd122070312) / 64'd244140625;
    qco[4] = (64'd3856070063 * 65536 + 64'd122070312) / 64'd244140625;

    add_item(32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 0);
    add_item(32'h0000_0001, 32'h0000_0000, 31'h0001_0000, 0);
    add_item(32'h8000_0000, 32'h0000_0000, 31'h0001_0000, 0);
    add_item(32'h7FFF_FFFF, 32'h0000_0000, 31'h0001_0000, 0);
    add_item(32'h8000_0001, 32'h0000_0000, 31'h0001_0000, 0);
    add_item(32'hFFFF_FFFF, 32'h0000_0000, 31'h0001_0000, 0);
    add_item(32'h4000_0000, 32'h0003_0000, 31'h0002_8000, 0);
    add_item(32'hC000_0000, 32'hFFFD_0000, 31'h0002_8000, 0);
    add_item(32'h1234_5678, 32'h7FFF_FFFF, 31'h0000_0000, 0);
    add_item(32'hFFFF_FFFF, 32'h8000_0000, 31'h0000_0000, 0);
    add_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
    add_item(32'h0000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 0);
    add_item(32'h0000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
    add_item(32'hFFFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 0);
    add_item(32'h0000_0001, 32'h0000_0000, 31'h7FFF_FFFF, 0);
    add_item(32'hFFFF_FFFF, 32'h0000_0000, 31'h7FFF_FFFF, 0);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
    add_item(32'h6B1C_0000, 32'hFFFF_FFFF, 31'h0000_0001, 0);
    add_item(32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA, 1);

    for (int i = 0; i < 1200; i++) begin
      case ($urandom_range(0, 5))
        0: u = $urandom_range(0, 255);
        1: u = 32'hFFFF_FFFF - $urandom_range(0, 255);
        2: u = 32'h8000_0000 + $urandom_range(0, 64) - 32;
        default: u = $urandom;
      endcase
      m = $urandom;
      if ($urandom_range(0, 3) != 0) m = $signed(m) >>> $urandom_range(0, 24);
      s = 31'($urandom) >> $urandom_range(0, 30);
      add_item(u, m, s, $urandom_range(0, 199) == 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() > 0 || start) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results (%0d clamped).",
             n_sent, n_checked, n_sat);
    $display("Covered zero, half and extreme uniforms, both tails, zero and full std_dev.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ins_pkg.sv
rtl/ins_log_cell.sv
rtl/ins_sqrt_cell.sv
rtl/ins_horner_cell.sv
rtl/ins_div_cell.sv
rtl/inverse_normal_sample_top.sv
tb/sv/inverse_normal_sample_top_tb.sv
